[design/text_mode_character_generator_assert.svh]
// Assertion macro for the text-mode character generator.
`ifndef TEXT_MODE_CHARACTER_GENERATOR_ASSERT_SVH
`define TEXT_MODE_CHARACTER_GENERATOR_ASSERT_SVH

// Property that must hold whenever reset is released.
`define TMCG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

[design/tmcg_pkg.sv]
// ----------------------------------------------------------------------------
// tmcg_pkg
// Types and constants shared by the text-mode character generator.
// ----------------------------------------------------------------------------
`default_nettype none
package tmcg_pkg;
  localparam int PageBytes  = 1024;
  localparam int FontBytes  = 2048;
  localparam int PageAw     = $clog2(PageBytes);
  localparam int FontAw     = $clog2(FontBytes);
  localparam int ScreenCols = 40;
  localparam int ScreenLines = 24;

  localparam logic [2:0] FuncWrite = 3'd0;
  localparam logic [2:0] FuncTick  = 3'd1;
  localparam logic [2:0] FuncRender = 3'd2;
  localparam logic [2:0] FuncFont  = 3'd3;
  localparam logic [2:0] FuncClear = 3'd4;

  localparam logic [1:0] RegColour = 2'd0;
  localparam logic [1:0] RegStart  = 2'd1;
  localparam logic [1:0] RegEnd    = 2'd2;
  localparam logic [1:0] RegFlash  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic       latch;      // capture input word
    logic       wr_text;    // shadow write (clear sweep or bus write)
    logic       clr_sweep;  // clearing pass after reset
    logic       wr_font;
    logic       clr_dirty;
    logic       tick;       // advance flash counter
    logic       scan_start; // reset scan pointer
    logic       scan_step;  // one shadow byte per cycle
    logic       rd_cell;
    logic       rd_font;    // fetch glyph row
    logic       emit_row;
    logic       emit_status;
  } ctrl_t;

  typedef struct packed {
    logic bus_write;   // write hits the window
    logic flash_hit;   // toggle due on this tick
    logic scan_done;
    logic sweep_done;
    logic row_last;
    logic render_ok;
  } stat_t;

  function automatic logic [31:0] mode_colour(input logic [1:0] m);
    unique case (m)
      2'd1:    mode_colour = 32'hFFBF00FF;
      2'd2:    mode_colour = 32'h009933FF;
      default: mode_colour = 32'hFFFFFFFF;
    endcase
  endfunction
endpackage
`default_nettype wire

[design/tmcg_datapath.sv]
// ----------------------------------------------------------------------------
// tmcg_datapath
// Shadow and font memories, window decode, flash scan and pixel formatting.
// ----------------------------------------------------------------------------
`default_nettype none
module tmcg_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tmcg_pkg::ctrl_t      ctrl_i,
  output tmcg_pkg::stat_t           stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic [2:0]           func_i,
  input  wire logic [15:0]          bus_address_i,
  input  wire logic [7:0]           bus_data_i,
  input  wire logic [5:0]           column_i,
  input  wire logic [4:0]           line_i,
  input  wire logic [10:0]          font_index_i,
  input  wire logic [7:0]           font_byte_i,
  output logic                      strobe_o,
  output logic [2:0]                glyph_row_o,
  output logic [31:0]               pix0_o,
  output logic [31:0]               pix1_o,
  output logic [31:0]               pix2_o,
  output logic [31:0]               pix3_o,
  output logic [31:0]               pix4_o,
  output logic [31:0]               pix5_o,
  output logic [31:0]               pix6_o,
  output logic                      last_row_o,
  output logic [23:0]               dirty_mask_o,
  output logic                      flash_on_o
);
  localparam int Aw = tmcg_pkg::PageAw;
  localparam int Fw = tmcg_pkg::FontAw;

  logic [1:0]  colour_mode_q;
  logic [15:0] page_start_q, page_end_q;
  logic [5:0]  flash_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_mode_q  <= '0;
      page_start_q   <= 16'd1024;
      page_end_q     <= 16'd2047;
      flash_period_q <= 6'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tmcg_pkg::RegColour: colour_mode_q  <= cfg_data_i[1:0];
        tmcg_pkg::RegStart:  page_start_q   <= cfg_data_i;
        tmcg_pkg::RegEnd:    page_end_q     <= cfg_data_i;
        default:             flash_period_q <= cfg_data_i[5:0];
      endcase
    end
  end

  // captured input word
  logic [2:0]  func_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q, fbyte_q;
  logic [5:0]  col_q;
  logic [4:0]  line_q;
  logic [10:0] fidx_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      func_q  <= func_i;
      addr_q  <= bus_address_i;
      data_q  <= bus_data_i;
      col_q   <= column_i;
      line_q  <= line_i;
      fidx_q  <= font_index_i;
      fbyte_q <= font_byte_i;
    end
  end

  // window decode
  logic [16:0] last_w, lim_w;
  logic [15:0] rel_w;
  logic [4:0]  wline_w;
  logic [2:0]  grp_w;
  always_comb begin
    lim_w  = {1'b0, page_start_q} + 17'(tmcg_pkg::PageBytes - 1);
    last_w = ({1'b0, page_end_q} > lim_w) ? lim_w : {1'b0, page_end_q};
    rel_w  = addr_q - page_start_q;
    // offset in 128-byte block divided by 40: three-way compare
    if (rel_w[6:0] >= 7'd120)     grp_w = 3'd3;
    else if (rel_w[6:0] >= 7'd80) grp_w = 3'd2;
    else if (rel_w[6:0] >= 7'd40) grp_w = 3'd1;
    else                          grp_w = 3'd0;
    wline_w = {grp_w[1:0], rel_w[9:7]};
  end
  assign stat_o.bus_write = (addr_q >= page_start_q) && ({1'b0, addr_q} <= last_w);

  // clearing sweep and flash scan pointers
  logic [Aw:0] sweep_q;
  logic [4:0]  sline_q;
  logic [5:0]  scol_q;
  logic [23:0] dirty_q;
  logic [5:0]  fcount_q;
  logic        phase_q;
  logic [5:0]  fcount_inc;
  assign fcount_inc = fcount_q + 6'd1;
  assign stat_o.flash_hit = fcount_inc >= flash_period_q;
  assign stat_o.sweep_done = sweep_q[Aw];
  assign stat_o.scan_done = (sline_q == 5'(tmcg_pkg::ScreenLines - 1)) &&
                            (scol_q == 6'(tmcg_pkg::ScreenCols - 1));
  assign stat_o.render_ok = (col_q < 6'(tmcg_pkg::ScreenCols)) &&
                            (line_q < 5'(tmcg_pkg::ScreenLines));

  function automatic logic [Aw-1:0] cell_addr(input logic [4:0] l, input logic [5:0] c);
    logic [Aw+1:0] s;
    s = (Aw+2)'({l[2:0], 7'd0}) + (Aw+2)'(l[4:3]) * (Aw+2)'(7'd40) + (Aw+2)'(c);
    return s[Aw-1:0];
  endfunction

  // shadow memory
  logic [7:0]    text_mem [tmcg_pkg::PageBytes];
  logic [7:0]    text_rd_q;
  logic [Aw-1:0] twa, tra;
  logic [7:0]    twd;
  always_comb begin
    twa = ctrl_i.clr_sweep ? sweep_q[Aw-1:0] : rel_w[Aw-1:0];
    twd = ctrl_i.clr_sweep ? 8'd0 : data_q;
    tra = ctrl_i.scan_step ? cell_addr(sline_q, scol_q) : cell_addr(line_q, col_q);
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_text) text_mem[twa] <= twd;
    text_rd_q <= text_mem[tra];
  end

  // scan: read issued at step, result checked in the cycle after
  logic       scan_v_q;
  logic [4:0] scan_l_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0; sline_q <= '0; scol_q <= '0; scan_v_q <= 1'b0;
      scan_l_q <= '0; dirty_q <= '0; fcount_q <= '0; phase_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_sweep) sweep_q <= sweep_q + (Aw+1)'(1);
      if (ctrl_i.scan_start) begin
        sline_q <= '0; scol_q <= '0;
      end else if (ctrl_i.scan_step) begin
        if (scol_q == 6'(tmcg_pkg::ScreenCols - 1)) begin
          scol_q <= '0; sline_q <= sline_q + 5'd1;
        end else begin
          scol_q <= scol_q + 6'd1;
        end
      end
      scan_v_q <= ctrl_i.scan_step;
      scan_l_q <= sline_q;
      if (scan_v_q && text_rd_q[7:6] == 2'b01) dirty_q[scan_l_q] <= 1'b1;
      if (ctrl_i.wr_text && !ctrl_i.clr_sweep && wline_w < 5'(tmcg_pkg::ScreenLines))
        dirty_q[wline_w] <= 1'b1;
      if (ctrl_i.clr_dirty && line_q < 5'(tmcg_pkg::ScreenLines)) dirty_q[line_q] <= 1'b0;
      if (ctrl_i.tick) begin
        if (stat_o.flash_hit) begin
          fcount_q <= '0; phase_q <= ~phase_q;
        end else begin
          fcount_q <= fcount_inc;
        end
      end
    end
  end

  // font memory, undefined until loaded
  logic [7:0]    font_mem [tmcg_pkg::FontBytes];
  logic [7:0]    font_rd_q;
  logic [7:0]    ch_q;
  logic [2:0]    row_q, orow_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_font) font_mem[fidx_q[Fw-1:0]] <= fbyte_q;
    if (ctrl_i.rd_font) font_rd_q <= font_mem[{ch_q, row_q}];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; orow_q <= '0; ch_q <= '0;
    end else begin
      if (ctrl_i.rd_cell) ch_q <= text_rd_q;
      if (ctrl_i.latch) row_q <= '0;
      else if (ctrl_i.rd_font) row_q <= row_q + 3'd1;
      if (ctrl_i.rd_font) orow_q <= row_q;
    end
  end
  assign stat_o.row_last = (orow_q == 3'd7);

  // output register
  logic        inv_w;
  logic [31:0] colour_w;
  logic [31:0] px_w [7];
  always_comb begin
    inv_w = (ch_q[7:6] == 2'b00) || (ch_q[7:6] == 2'b01 && phase_q);
    colour_w = tmcg_pkg::mode_colour(colour_mode_q);
    for (int p = 0; p < 7; p++)
      px_w[p] = ctrl_i.emit_row ? ({32{font_rd_q[6-p] ^ inv_w}} & colour_w) : 32'd0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_o <= 1'b0;
    else strobe_o <= ctrl_i.emit_row || ctrl_i.emit_status;
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_row || ctrl_i.emit_status) begin
      glyph_row_o <= ctrl_i.emit_row ? orow_q : 3'd0;
      last_row_o  <= ctrl_i.emit_status || stat_o.row_last;
      pix0_o <= px_w[0]; pix1_o <= px_w[1]; pix2_o <= px_w[2]; pix3_o <= px_w[3];
      pix4_o <= px_w[4]; pix5_o <= px_w[5]; pix6_o <= px_w[6];
      dirty_mask_o <= dirty_q;
      flash_on_o   <= phase_q;
    end
  end
  logic unused_w;
  assign unused_w = ^{func_q, rel_w[15:10], grp_w[2]};
endmodule
`default_nettype wire

[design/tmcg_ctrl.sv]
// ----------------------------------------------------------------------------
// tmcg_ctrl
// Sequencer: clearing pass, command decode, flash scan and render rows.
// ----------------------------------------------------------------------------
`default_nettype none
module tmcg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic [2:0]       func_i,
  output logic                  busy,
  input  wire tmcg_pkg::stat_t  stat_i,
  output tmcg_pkg::ctrl_t       ctrl_o
);
  localparam logic [2:0] StSweep  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StExec   = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StDrain  = 3'd4;
  localparam logic [2:0] StCell   = 3'd5;
  localparam logic [2:0] StRows   = 3'd6;
  localparam logic [2:0] StStatus = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] func_q;
  logic       first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StSweep; func_q <= '0; first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start && !busy) func_q <= func_i;
      first_q <= (state_q == StCell);
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    ctrl_o.latch = start && !busy;
    unique case (state_q)
      StSweep: begin
        ctrl_o.clr_sweep = !stat_i.sweep_done;
        ctrl_o.wr_text   = !stat_i.sweep_done;
        if (stat_i.sweep_done) state_d = StIdle;
      end
      StIdle: if (start) state_d = StExec;
      StExec: begin
        state_d = StStatus;
        priority case (func_q)
          tmcg_pkg::FuncWrite: ctrl_o.wr_text = stat_i.bus_write;
          tmcg_pkg::FuncFont:  ctrl_o.wr_font = 1'b1;
          tmcg_pkg::FuncClear: ctrl_o.clr_dirty = 1'b1;
          tmcg_pkg::FuncTick: begin
            ctrl_o.tick = 1'b1;
            ctrl_o.scan_start = 1'b1;
            if (stat_i.flash_hit) state_d = StScan;
          end
          tmcg_pkg::FuncRender: if (stat_i.render_ok) state_d = StCell;
          default: ;
        endcase
      end
      StScan: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_d = StDrain;
      end
      StDrain: state_d = StStatus;
      StCell: begin
        ctrl_o.rd_cell = 1'b1;
        state_d = StRows;
      end
      StRows: begin
        ctrl_o.rd_font  = !stat_i.row_last || first_q;
        ctrl_o.emit_row = !first_q;
        if (!first_q && stat_i.row_last) state_d = StIdle;
      end
      default: begin
        ctrl_o.emit_status = 1'b1;
        state_d = StIdle;
      end
    endcase
  end
  logic unused_w;
  assign unused_w = ^func_q;
endmodule
`default_nettype wire

[design/text_mode_character_generator.sv]
// A bus write, font load, clear or tick without a toggle ends with a status word on the outputs.
// One item at a time.
// A render gives its first glyph row word after the cell read and first font read, then 8 in a row.
// A flash toggle tick scans the 960 shadow cells, one a cycle, then emits a status word.
// After reset a clearing pass zeroes the shadow memory while busy is high.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// text_mode_character_generator
// 40x24 interleaved text-mode generator: top level.
// ----------------------------------------------------------------------------
`default_nettype none
module text_mode_character_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             strobe,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [2:0]  func_i,
  input  wire logic [15:0] bus_address_i,
  input  wire logic [7:0]  bus_data_i,
  input  wire logic [5:0]  column_i,
  input  wire logic [4:0]  line_i,
  input  wire logic [10:0] font_index_i,
  input  wire logic [7:0]  font_byte_i,
  output logic [2:0]       glyph_row_o,
  output logic [31:0]      pix0_o,
  output logic [31:0]      pix1_o,
  output logic [31:0]      pix2_o,
  output logic [31:0]      pix3_o,
  output logic [31:0]      pix4_o,
  output logic [31:0]      pix5_o,
  output logic [31:0]      pix6_o,
  output logic             last_row_o,
  output logic [23:0]      dirty_mask_o,
  output logic             flash_on_o
);
  tmcg_pkg::ctrl_t ctrl;
  tmcg_pkg::stat_t stat;

  tmcg_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .func_i, .busy, .stat_i(stat), .ctrl_o(ctrl)
  );

  tmcg_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .func_i, .bus_address_i, .bus_data_i, .column_i, .line_i,
    .font_index_i, .font_byte_i,
    .strobe_o(strobe), .glyph_row_o, .pix0_o, .pix1_o, .pix2_o, .pix3_o,
    .pix4_o, .pix5_o, .pix6_o, .last_row_o, .dirty_mask_o, .flash_on_o
  );
endmodule
`default_nettype wire

[design/tmcg_checker.sv]
// ----------------------------------------------------------------------------
// tmcg_checker
// Port-level checks on the character generator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_mode_character_generator_assert.svh"
module tmcg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [2:0] glyph_row_o,
  input wire logic       last_row_o
);
  // every word is launched from a busy cycle
  `TMCG_ASSERT(a_word_after_busy, strobe |-> $past(busy), "word not preceded by busy")
  `TMCG_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item not busy")
  `TMCG_ASSERT(a_row_step, (strobe && !last_row_o) |=> (strobe && glyph_row_o == $past(glyph_row_o) + 3'd1), "glyph row gap")
  `TMCG_ASSERT(a_last_ends, (strobe && last_row_o) |=> !strobe, "word after last")
endmodule

bind text_mode_character_generator tmcg_checker u_tmcg_checker (
  .clk_i, .rst_ni, .start, .busy, .strobe, .glyph_row_o, .last_row_o
);
`default_nettype wire
